@@ src/lsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the line sensor centroid unit
// Fixed-point widths, reset levels, register indexes and the divider request.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int NUM_CH      = 6;
	localparam int SAMPLE_BITS = 12;
	localparam int LVL_W       = 16;                 // Q0.16 level
	localparam int NORM_W      = LVL_W + 1;          // 0..1.0 inclusive
	localparam int GAIN_W      = LVL_W + 1;
	localparam int WGT_W       = 16;
	localparam int CH_W        = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
	localparam int TOTAL_W     = NORM_W + $clog2(NUM_CH + 1);
	localparam int OPA_W       = GAIN_W + 1;         // signed multiplier operand a
	localparam int OPB_W       = LVL_W + 1;          // signed multiplier operand b
	localparam int PROD_W      = OPA_W + OPB_W;
	localparam int WSUM_W      = PROD_W + $clog2(NUM_CH + 1);
	localparam int DVD_W       = WSUM_W;
	localparam int DVS_W       = TOTAL_W;
	localparam int STEP_W      = $clog2(DVD_W + 1);
	localparam int ERR_W       = 16;
	localparam int CFG_IDX_W   = $clog2(NUM_CH + 2);
	localparam int CFG_DATA_W  = GAIN_W;
	localparam int IN_DATA_W   = ((NUM_CH * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((ERR_W + NUM_CH * NORM_W + 7) / 8) * 8;

	localparam logic [NORM_W-1:0] ONE_Q16   = NORM_W'(65536);
	localparam logic [NORM_W-1:0] HALF_Q16  = NORM_W'(32768);
	localparam logic [LVL_W-1:0]  FILT_RST  = LVL_W'(32768);
	localparam logic [LVL_W-1:0]  BLACK_RST = LVL_W'(52429);
	localparam logic [LVL_W-1:0]  WHITE_RST = LVL_W'(13107);
	localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(32768);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WGT0 = CFG_IDX_W'(1);

	localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(LVL_W);
	localparam logic [STEP_W-1:0] CEN_STEPS  = STEP_W'(DVD_W);

	typedef struct packed {
		logic              start;
		logic [DVS_W-1:0]  rem_init;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

@@ src/line_sensor_centroid_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_centroid_unit: six-channel reflectance line position finder
// Filters each scan, tracks calibration extremes, normalizes and forms a
// weighted centroid with one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one scan per word: tdata holds the six 12-bit samples, tuser
//   selects calibrate (0) or measure (1). m_* returns one word per scan:
//   tuser is the line-found flag, tdata holds the centroid and six norms.
//   wr_en / wr_index / wr_data write the gain (index 0) and the six weights
//   (indexes 1..6); other indexes are dropped. The user must write only
//   while the unit is idle; the unit itself does not enforce this.
// Timing:
//   One scan at a time. Per channel: filter update, then in measure mode a
//   range check, a 16-step normalization division when the level lies
//   strictly between white and black, and weighting. A found line adds the
//   38-step centroid division on the shared divider. s_tready is high only
//   while idle.
// Reset and stall:
//   Reset clears the registers to gain 0.5, weights 0, filters 0.5, black
//   0.8, white 0.2. A result waits in the output register while m_tready is
//   low; the next scan is accepted meanwhile but its result is held back.
// ----------------------------------------------------------------------------
module line_sensor_centroid_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lsc_pkg::IN_DATA_W-1:0]    s_tdata,  // sample_0 .. sample_5, 12 bits each
	input  logic                             s_tuser,  // cmd
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lsc_pkg::OUT_DATA_W-1:0]   m_tdata,  // line_offset, norm_0 .. norm_5
	output logic                             m_tuser,  // line_found
	// configuration
	input  logic                             wr_en,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [lsc_pkg::CFG_DATA_W-1:0]   wr_data
);
	import lsc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EMA_MUL,
		S_EMA_ADD,
		S_NORM,
		S_NDIV,
		S_WMUL,
		S_WACC,
		S_CEN,
		S_CDIV,
		S_FINISH
	} state_t;

	state_t state_q;

	// configuration registers
	logic [GAIN_W-1:0]        gain_q;
	logic signed [WGT_W-1:0]  wgt_q [NUM_CH];

	// per-channel state
	logic [LVL_W-1:0] filt_q  [NUM_CH];
	logic [LVL_W-1:0] black_q [NUM_CH];
	logic [LVL_W-1:0] white_q [NUM_CH];

	// current scan
	logic [SAMPLE_BITS-1:0]    samp_q [NUM_CH];
	logic                      meas_q;
	logic [CH_W-1:0]           ch_q;
	logic [LVL_W-1:0]          f_q;
	logic [NORM_W-1:0]         n_q;
	logic [NORM_W-1:0]         norm_q [NUM_CH];
	logic [TOTAL_W-1:0]        total_q;
	logic signed [WSUM_W-1:0]  wsum_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [PROD_W-1:0]  prod_q;

	// output register
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_user_q;

	// shared multiplier and its operands
	logic [GAIN_W-1:0]        gain_eff;
	logic [LVL_W-1:0]         x_cur;
	logic signed [OPA_W-1:0]  op_a;
	logic signed [OPB_W-1:0]  op_b;
	logic signed [PROD_W-1:0] mul_out;
	logic signed [PROD_W:0]   ema_sum;
	logic [LVL_W-1:0]         f_new;

	// normalization and centroid
	logic [LVL_W-1:0]  b_cur;
	logic [LVL_W-1:0]  w_cur;
	logic              last_ch;
	logic              found;
	logic [DVD_W-1:0]  wmag;
	div_req_t          div_req;
	logic              div_busy;
	logic [DVD_W-1:0]  div_quo;
	logic [NORM_W-1:0] n_div;
	logic signed [ERR_W-1:0] err_sat;
	logic [OUT_DATA_W-1:0]   out_pack;

	assign gain_eff = (gain_q > ONE_Q16) ? ONE_Q16 : gain_q;
	assign x_cur    = LVL_W'(samp_q[ch_q]) << (LVL_W - SAMPLE_BITS);
	assign b_cur    = black_q[ch_q];
	assign w_cur    = white_q[ch_q];
	assign last_ch  = ch_q == CH_W'(NUM_CH - 1);
	assign found    = total_q > TOTAL_W'(HALF_Q16);

	// filter uses a*(x-f); weighting uses n*weight
	always_comb begin
		if (state_q == S_WMUL) begin
			op_a = signed'({1'b0, n_q});
			op_b = OPB_W'(wgt_q[ch_q]);
		end else begin
			op_a = signed'({1'b0, gain_eff});
			op_b = signed'({1'b0, x_cur}) - signed'({1'b0, filt_q[ch_q]});
		end
	end
	assign mul_out = op_a * op_b;

	// f + a*(x-f), rounded half up
	assign ema_sum = signed'((PROD_W+1)'({filt_q[ch_q], LVL_W'(0)}))
		+ (PROD_W+1)'(prod_q) + signed'((PROD_W+1)'(HALF_Q16));
	assign f_new   = ema_sum[2*LVL_W-1:LVL_W];

	assign wmag  = wsum_q[WSUM_W-1] ? DVD_W'(-wsum_q) : DVD_W'(wsum_q);
	assign n_div = ONE_Q16 - NORM_W'(div_quo[LVL_W-1:0]);

	// truncate toward zero, then saturate to the output range
	always_comb begin
		if (wsum_q[WSUM_W-1]) begin
			err_sat = (div_quo > DVD_W'(32768)) ? ERR_W'(-32768)
				: ERR_W'(-signed'(div_quo[ERR_W:0]));
		end else begin
			err_sat = (div_quo > DVD_W'(32767)) ? ERR_W'(32767) : ERR_W'(div_quo[ERR_W-1:0]);
		end
	end

	always_comb begin
		div_req = '0;
		if (state_q == S_NORM && b_cur > w_cur && f_q > w_cur && f_q < b_cur) begin
			div_req.start    = 1'b1;
			div_req.rem_init = DVS_W'(f_q - w_cur);
			div_req.divisor  = DVS_W'(b_cur - w_cur);
			div_req.steps    = NORM_STEPS;
		end else if (state_q == S_CEN && found) begin
			div_req.start    = 1'b1;
			div_req.dividend = wmag;
			div_req.divisor  = total_q;
			div_req.steps    = CEN_STEPS;
		end
	end

	lsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_comb begin
		out_pack = '0;
		out_pack[ERR_W-1:0] = err_q;
		for (int i = 0; i < NUM_CH; i++) begin
			out_pack[ERR_W + i*NORM_W +: NORM_W] = meas_q ? norm_q[i] : '0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			for (int i = 0; i < NUM_CH; i++) begin
				wgt_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == REG_GAIN) begin
				gain_q <= wr_data;
			end else if (wr_index <= CFG_IDX_W'(NUM_CH)) begin
				wgt_q[CH_W'(wr_index - REG_WGT0)] <= wr_data[WGT_W-1:0];
			end
		end
	end

	// sequencer, channel state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				filt_q[i]  <= FILT_RST;
				black_q[i] <= BLACK_RST;
				white_q[i] <= WHITE_RST;
			end
		end else begin
			// load a finished word when the register is free, else drop on accept
			if (state_q == S_FINISH && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ch_q    <= '0;
						state_q <= S_EMA_MUL;
					end
				end
				S_EMA_MUL: begin
					state_q <= S_EMA_ADD;
				end
				S_EMA_ADD: begin
					filt_q[ch_q] <= f_new;
					if (meas_q) begin
						state_q <= S_NORM;
					end else begin
						if (f_new > black_q[ch_q]) begin
							black_q[ch_q] <= f_new;
						end
						if (f_new < white_q[ch_q]) begin
							white_q[ch_q] <= f_new;
						end
						if (last_ch) begin
							state_q <= S_FINISH;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= S_EMA_MUL;
						end
					end
				end
				S_NORM: begin
					state_q <= div_req.start ? S_NDIV : S_WMUL;
				end
				S_NDIV: begin
					if (!div_busy) begin
						state_q <= S_WMUL;
					end
				end
				S_WMUL: begin
					state_q <= S_WACC;
				end
				S_WACC: begin
					if (last_ch) begin
						state_q <= S_CEN;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_EMA_MUL;
					end
				end
				S_CEN: begin
					state_q <= found ? S_CDIV : S_FINISH;
				end
				S_CDIV: begin
					if (!div_busy) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					for (int i = 0; i < NUM_CH; i++) begin
						samp_q[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
					end
					meas_q  <= s_tuser;
					total_q <= '0;
					wsum_q  <= '0;
					err_q   <= '0;
				end
			end
			S_EMA_MUL: begin
				prod_q <= mul_out;
			end
			S_EMA_ADD: begin
				f_q <= f_new;
			end
			S_NORM: begin
				// saturating cases settle without the divider
				if (b_cur <= w_cur || f_q >= b_cur) begin
					n_q <= '0;
				end else if (f_q <= w_cur) begin
					n_q <= ONE_Q16;
				end
			end
			S_NDIV: begin
				if (!div_busy) begin
					n_q <= n_div;
				end
			end
			S_WMUL: begin
				prod_q       <= mul_out;
				norm_q[ch_q] <= n_q;
				total_q      <= total_q + TOTAL_W'(n_q);
			end
			S_WACC: begin
				wsum_q <= wsum_q + WSUM_W'(prod_q);
			end
			S_CDIV: begin
				if (!div_busy) begin
					err_q <= err_sat;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= out_pack;
					out_user_q <= meas_q && found;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[ERR_W-1:0] == '0)
		else $error("centroid nonzero without a line");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_busy)
		else $error("divider busy while sequencer idle");
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WMUL |-> n_q <= ONE_Q16)
		else $error("normalized value above one");
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= CH_W'(NUM_CH - 1))
		else $error("channel index out of range");

endmodule

@@ src/lsc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_div: shared restoring divider
// One quotient bit per cycle; the remainder may start preloaded so that a
// fraction (r << k) / d with r < d costs only k steps.
// ----------------------------------------------------------------------------
module lsc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lsc_pkg::div_req_t          req,
	output logic                       busy,
	output logic [lsc_pkg::DVD_W-1:0]  quotient
);
	import lsc_pkg::*;

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;

	logic [DVS_W:0] rem_sh;
	logic           fits;
	logic [DVS_W:0] rem_diff;

	assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with zero step count");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider restarted while busy");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for line_sensor_centroid_unit
// Streams calibrate and measure scans into the unit, predicts every result
// word from an internal fixed-point model of the filter, the calibration
// extremes, the normalization and the centroid, and compares field by field.
// Directed checks (reset levels, spare register, gain, calibration and
// centroid limits) come first, then four random phases, idling differently.
// ----------------------------------------------------------------------------
module testbench;
	import lsc_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 2_500_000;
	localparam int PHASE_SCANS  = 470;
	localparam int SETTLE       = 4;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS  = 10;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
	localparam longint ERR_POS_MAX = 32767;
	localparam longint ERR_NEG_MAG = 32768;
	// first index past the last weight register: the unit must drop it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(NUM_CH + 1);

	typedef enum logic {SCAN_CAL = 1'b0, SCAN_MEAS = 1'b1} scan_kind_e;
	typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] scan_t;
	typedef int weight_set_t [NUM_CH];
	typedef struct packed {
		logic                          found;
		logic [ERR_W-1:0]              err;
		logic [NUM_CH-1:0][NORM_W-1:0] norm;
	} scan_result_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tuser;
	logic                   wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]   wr_index = '0;
	logic [CFG_DATA_W-1:0]  wr_data  = '0;

	// shadow copy of the unit's registers and per-channel levels
	logic [GAIN_W-1:0]       gain_reg;
	logic signed [WGT_W-1:0] weight_reg [NUM_CH];
	logic [LVL_W-1:0]        filt_lvl   [NUM_CH];
	logic [LVL_W-1:0]        black_lvl  [NUM_CH];
	logic [LVL_W-1:0]        white_lvl  [NUM_CH];

	scan_result_t pending_results [$];
	int           mismatches = 0;
	int unsigned  cycles     = 0;
	int           idle_pct   = 0;
	int           stall_pct  = 0;
	int           line_pos   = 0;

	line_sensor_centroid_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // sample_0 .. sample_5, 12 bits each
		.s_tuser  (s_tuser),   // cmd
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // line_offset, norm_0 .. norm_5
		.m_tuser  (m_tuser),   // line_found
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Guard against a hung handshake; the run ends here on a stuck unit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void reset_levels();
		gain_reg = GAIN_RST;
		for (int i = 0; i < NUM_CH; i++) begin
			weight_reg[i] = '0;
			filt_lvl[i]   = FILT_RST;
			black_lvl[i]  = BLACK_RST;
			white_lvl[i]  = WHITE_RST;
		end
	endfunction

	// EMA step, rounded half up; any gain above 1.0 acts as 1.0
	function automatic logic [LVL_W-1:0] filter_step(input logic [LVL_W-1:0] f,
	                                                 input logic [SAMPLE_BITS-1:0] s);
		longint unsigned a, x, acc;
		a   = (gain_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(gain_reg);
		x   = longint'(s) << (LVL_W - SAMPLE_BITS);
		acc = a * x + (longint'(ONE_Q16) - a) * longint'(f) + longint'(HALF_Q16);
		return LVL_W'(acc >> LVL_W);
	endfunction

	// white reads 1.0, black reads 0.0; a collapsed span reads 0
	function automatic logic [NORM_W-1:0] norm_level(input logic [LVL_W-1:0] f,
	                                                 input logic [LVL_W-1:0] b,
	                                                 input logic [LVL_W-1:0] w);
		longint unsigned q;
		if (b <= w) return '0;
		if (f <= w) return ONE_Q16;
		if (f >= b) return '0;
		q = (longint'(f - w) << LVL_W) / longint'(b - w);
		return (q >= longint'(ONE_Q16)) ? '0 : NORM_W'(longint'(ONE_Q16) - q);
	endfunction

	// Advance the shadow levels by one scan and return the word it yields.
	function automatic scan_result_t predict_scan(input scan_kind_e kind, input scan_t scan);
		scan_result_t r;
		longint total, wsum, mag, q;
		r     = '0;
		total = 0;
		wsum  = 0;
		for (int i = 0; i < NUM_CH; i++) begin
			filt_lvl[i] = filter_step(filt_lvl[i], scan[i]);
			if (kind == SCAN_CAL) begin
				if (filt_lvl[i] > black_lvl[i]) black_lvl[i] = filt_lvl[i];
				if (filt_lvl[i] < white_lvl[i]) white_lvl[i] = filt_lvl[i];
			end else begin
				r.norm[i] = norm_level(filt_lvl[i], black_lvl[i], white_lvl[i]);
				total += longint'(r.norm[i]);
				wsum  += longint'(r.norm[i]) * longint'(weight_reg[i]);
			end
		end
		// centroid only when the summed reading clears one half
		if (kind == SCAN_MEAS && total > longint'(HALF_Q16)) begin
			mag     = (wsum < 0) ? -wsum : wsum;
			q       = mag / total;
			r.found = 1'b1;
			if (wsum < 0) begin
				r.err = (q > ERR_NEG_MAG) ? ERR_W'(-ERR_NEG_MAG) : ERR_W'(-q);
			end else begin
				r.err = (q > ERR_POS_MAX) ? ERR_W'(ERR_POS_MAX) : ERR_W'(q);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: one word per handshake, compared with the oldest
	// prediction; the ready line stalls at random per the current phase
	// ------------------------------------------------------------------
	task automatic check_word();
		scan_result_t got, want;
		got.found = m_tuser;
		got.err   = m_tdata[ERR_W-1:0];
		got.norm  = m_tdata[ERR_W +: NUM_CH*NORM_W];
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected result word: found %0d err %0d norms %h",
				         got.found, $signed(got.err), got.norm);
		end else begin
			want = pending_results.pop_front();
			if (got.found !== want.found || got.err !== want.err
			    || got.norm !== want.norm) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: found exp %0d act %0d, err exp %0d act %0d, norms exp %h act %h",
					         want.found, got.found, $signed(want.err), $signed(got.err),
					         want.norm, got.norm);
			end
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (m_tvalid && m_tready) check_word();
	end

	// ------------------------------------------------------------------
	// Drivers: every task starts and returns right after a rising edge
	// ------------------------------------------------------------------
	task automatic send_scan(input scan_kind_e kind, input scan_t scan);
		// hold valid low for a random gap before presenting the word
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'(scan);
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_scan(kind, scan));
	endtask

	// Drop valid and wait until every predicted word has come back.
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		if (idx == REG_GAIN)
			gain_reg = data;
		else if (idx >= REG_WGT0 && idx < REG_WGT0 + NUM_CH)
			weight_reg[idx - REG_WGT0] = data[WGT_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic write_weights(input weight_set_t w);
		for (int i = 0; i < NUM_CH; i++)
			write_reg(REG_WGT0 + CFG_IDX_W'(i), CFG_DATA_W'(w[i]));
	endtask

	// ------------------------------------------------------------------
	// Scan patterns
	// ------------------------------------------------------------------
	function automatic scan_t flat_scan(input int v);
		scan_t s;
		for (int i = 0; i < NUM_CH; i++) s[i] = SAMPLE_BITS'(v);
		return s;
	endfunction

	function automatic scan_t random_scan(input int lo, input int hi);
		scan_t s;
		for (int i = 0; i < NUM_CH; i++) s[i] = SAMPLE_BITS'($urandom_range(hi, lo));
		return s;
	endfunction

	// each channel on one rail or the other
	function automatic scan_t rail_scan();
		scan_t s;
		for (int i = 0; i < NUM_CH; i++) s[i] = $urandom_range(1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
		return s;
	endfunction

	// dark channels read high; the line reflects and reads low
	function automatic scan_t line_scan(input int center, input int width);
		scan_t s;
		s = random_scan(3400, SAMPLE_MAX);
		for (int i = 0; i < width; i++)
			if (center + i < NUM_CH) s[center + i] = SAMPLE_BITS'($urandom_range(600, 0));
		return s;
	endfunction

	function automatic weight_set_t random_weights();
		weight_set_t w;
		for (int i = 0; i < NUM_CH; i++) w[i] = int'($urandom_range(65535)) - 32768;
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Measure against the reset levels with zero weights and half gain.
	task automatic test_reset_levels();
		send_scan(SCAN_MEAS, flat_scan(0));
		send_scan(SCAN_MEAS, flat_scan(SAMPLE_MAX));
		send_scan(SCAN_MEAS, flat_scan(SAMPLE_MAX));
		send_scan(SCAN_MEAS, rail_scan());
		wait_results_done();
	endtask

	// A write past the last weight must leave every register untouched.
	task automatic test_spare_register();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
		send_scan(SCAN_MEAS, random_scan(0, SAMPLE_MAX));
		wait_results_done();
	endtask

	// Zero gain freezes the filter; gains above 1.0 act as 1.0.
	task automatic test_filter_gain();
		write_reg(REG_GAIN, '0);
		send_scan(SCAN_MEAS, flat_scan(0));
		send_scan(SCAN_MEAS, flat_scan(SAMPLE_MAX));
		wait_results_done();
		write_reg(REG_GAIN, CFG_DATA_W'(ONE_Q16) + CFG_DATA_W'(1));
		send_scan(SCAN_MEAS, flat_scan(1000));
		wait_results_done();
		write_reg(REG_GAIN, '1);
		send_scan(SCAN_MEAS, flat_scan(3000));
		wait_results_done();
		write_reg(REG_GAIN, CFG_DATA_W'(ONE_Q16));
		send_scan(SCAN_MEAS, flat_scan(2048));
		wait_results_done();
	endtask

	// Widen black and white with two flat scans and a rail scan, then measure.
	task automatic test_calibration();
		send_scan(SCAN_CAL, flat_scan(3200));
		send_scan(SCAN_CAL, flat_scan(800));
		send_scan(SCAN_CAL, rail_scan());
		send_scan(SCAN_MEAS, flat_scan(2000));
		wait_results_done();
	endtask

	// Extreme weights, a line under each end, no line, and all channels lit.
	task automatic test_centroid_limits();
		write_weights('{32767, 4096, 0, -4096, -12288, -32768});
		send_scan(SCAN_MEAS, line_scan(0, 1));
		send_scan(SCAN_MEAS, line_scan(0, 1));
		send_scan(SCAN_MEAS, line_scan(NUM_CH - 1, 1));
		send_scan(SCAN_MEAS, flat_scan(SAMPLE_MAX));
		send_scan(SCAN_MEAS, flat_scan(0));
		wait_results_done();
		write_weights('{-32768, -32768, -32768, -32768, -32768, -32768});
		send_scan(SCAN_MEAS, flat_scan(0));
		wait_results_done();
	endtask

	// A drifting line, the most frequent pick, held over several scans so the
	// filter settles, mixed with calibration, noise, dark scans and rail scans.
	task automatic test_random_phase(input int in_idle, input int out_stall,
	                                 input logic [CFG_DATA_W-1:0] gain,
	                                 input weight_set_t w);
		int pick;
		wait_results_done();
		idle_pct  = in_idle;
		stall_pct = out_stall;
		write_reg(REG_GAIN, gain);
		write_weights(w);
		repeat (PHASE_SCANS) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < 30)
				line_pos = $urandom_range(1) ? (line_pos + 1) % NUM_CH
				                             : (line_pos + NUM_CH - 1) % NUM_CH;
			if (pick < 12)
				send_scan(SCAN_CAL, random_scan(0, SAMPLE_MAX));
			else if (pick < 60)
				send_scan(SCAN_MEAS, line_scan(line_pos, $urandom_range(2, 1)));
			else if (pick < 82)
				send_scan(SCAN_MEAS, random_scan(0, SAMPLE_MAX));
			else if (pick < 90)
				send_scan(SCAN_MEAS, random_scan(3400, SAMPLE_MAX));
			else
				send_scan(SCAN_MEAS, rail_scan());
		end
		wait_results_done();
	endtask

	initial begin
		reset_levels();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_levels();
		test_spare_register();
		test_filter_gain();
		test_calibration();
		test_centroid_limits();

		// no idling, sender idle, receiver stalling, both
		test_random_phase(0, 0, CFG_DATA_W'(ONE_Q16),
		                  '{-20480, -12288, -4096, 4096, 12288, 20480});
		test_random_phase(72, 0, CFG_DATA_W'($urandom_range(131071, 1)), random_weights());
		test_random_phase(0, 72, CFG_DATA_W'($urandom_range(65536, 1)),
		                  '{-32768, 32767, -32768, 32767, -32768, 32767});
		test_random_phase(23, 23, '1, random_weights());

		// let any stray word show up before deciding
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
src/lsc_pkg.sv
src/lsc_div.sv
src/line_sensor_centroid_unit.sv
dv/testbench.sv
